FILE: src/ubdc_pkg.sv
// ----------------------------------------------------------------------------
// ubdc_pkg: shared types and constants of the UART baud divisor calculator
// Field widths, register indexes, clock mode codes and the result word.
// ----------------------------------------------------------------------------
package ubdc_pkg;

    localparam int REF_W    = 26;
    localparam int PREDIV_W = 6;
    localparam int SEL_W    = 2;
    localparam int BAUD_W   = 24;
    localparam int MUL_W    = 8;
    localparam int PROD_W   = REF_W + MUL_W;
    localparam int FREF_W   = PROD_W;
    localparam int CLK_W    = FREF_W + 2;
    localparam int DIV_W    = FREF_W;
    localparam int DINT_W   = 16;
    localparam int DFRAC_W  = 4;
    localparam int MODE_W   = 2;
    localparam int ACT_W    = 32;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = REF_W;

    localparam logic [REF_W-1:0]    REF_RESET    = REF_W'(4000000);
    localparam logic [PREDIV_W-1:0] PREDIV_RESET = PREDIV_W'(1);
    localparam logic [SEL_W-1:0]    SEL_RESET    = '0;

    localparam logic [MUL_W-1:0] MUL_ZERO = MUL_W'(6);
    localparam logic [MUL_W-1:0] MUL_UNIT = MUL_W'(48);
    localparam int               MIN_DIV  = 16;
    localparam int               DIV_LIMIT = 32'h8000;
    // div/16 < DIV_LIMIT is div < 2**LIMIT_SHIFT
    localparam int               LIMIT_SHIFT = $clog2(DIV_LIMIT) + DFRAC_W;

    typedef enum logic [CFG_A_W-1:0] {
        REG_REF_CLOCK = 2'd0,
        REG_PREDIV    = 2'd1,
        REG_MULT_SEL  = 2'd2
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL = 2'd0,
        MODE_DOUBLE = 2'd1,
        MODE_QUAD   = 2'd2
    } rate_mode_t;

    typedef struct packed {
        logic [DINT_W-1:0]  divisor_integer;
        logic [DFRAC_W-1:0] divisor_fraction;
        logic [MODE_W-1:0]  rate_mode;
        logic [ACT_W-1:0]   actual_baud;
        logic               calc_error;
    } result_t;

    function automatic logic [MUL_W-1:0] mult_factor(input logic [SEL_W-1:0] sel);
        logic [MUL_W-1:0] f;
        if (sel == '0) begin
            f = MUL_ZERO;
        end else begin
            f = MUL_W'(sel) * MUL_UNIT;
        end
        return f;
    endfunction

endpackage

FILE: src/ubdc_div_cell.sv
// ----------------------------------------------------------------------------
// ubdc_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit in. Divisor and side data ride along.
// ----------------------------------------------------------------------------
module ubdc_div_cell #(
    parameter int ND = 36,
    parameter int DW = 24,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [ND-1:0] in_nq,
    input  logic [DW-1:0] in_rem,
    input  logic [DW-1:0] in_d,
    input  logic [SW-1:0] in_sb,
    output logic          out_valid,
    output logic [ND-1:0] out_nq,
    output logic [DW-1:0] out_rem,
    output logic [DW-1:0] out_d,
    output logic [SW-1:0] out_sb
);

    logic          valid_reg;
    logic [ND-1:0] nq_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] d_reg;
    logic [SW-1:0] sb_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;
    logic [DW-1:0] rem_next;
    logic [ND-1:0] nq_next;

    assign trial    = {in_rem, in_nq[ND-1]};
    assign diff     = trial - {1'b0, in_d};
    assign fits     = (trial >= {1'b0, in_d});
    assign rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
    assign nq_next  = {in_nq[ND-2:0], fits};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
            nq_reg    <= nq_next;
            rem_reg   <= rem_next;
            d_reg     <= in_d;
            sb_reg    <= in_sb;
        end
    end

    assign out_valid = valid_reg;
    assign out_nq    = nq_reg;
    assign out_rem   = rem_reg;
    assign out_d     = d_reg;
    assign out_sb    = sb_reg;

endmodule

FILE: src/ubdc_divider.sv
// ----------------------------------------------------------------------------
// ubdc_divider: pipelined restoring divider
// A row of ND division cells; one quotient bit is settled per cell, so a new
// word enters each enabled cycle and leaves from the last cell.
// ----------------------------------------------------------------------------
module ubdc_divider #(
    parameter int ND = 36,
    parameter int DW = 24,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [ND-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] in_sb,
    output logic          out_valid,
    output logic [ND-1:0] quotient,
    output logic [DW-1:0] remainder,
    output logic [DW-1:0] out_divisor,
    output logic [SW-1:0] out_sb
);

    logic          v  [ND+1];
    logic [ND-1:0] nq [ND+1];
    logic [DW-1:0] rm [ND+1];
    logic [DW-1:0] dv [ND+1];
    logic [SW-1:0] sb [ND+1];

    assign v[0]  = in_valid;
    assign nq[0] = dividend;
    assign rm[0] = '0;
    assign dv[0] = divisor;
    assign sb[0] = in_sb;

    for (genvar i = 0; i < ND; i++) begin : g_cell
        ubdc_div_cell #(
            .ND(ND),
            .DW(DW),
            .SW(SW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (v[i]),
            .in_nq    (nq[i]),
            .in_rem   (rm[i]),
            .in_d     (dv[i]),
            .in_sb    (sb[i]),
            .out_valid(v[i+1]),
            .out_nq   (nq[i+1]),
            .out_rem  (rm[i+1]),
            .out_d    (dv[i+1]),
            .out_sb   (sb[i+1])
        );
    end

    assign out_valid   = v[ND];
    assign quotient    = nq[ND];
    assign remainder   = rm[ND];
    assign out_divisor = dv[ND];
    assign out_sb      = sb[ND];

endmodule

FILE: src/uart_baud_divisor_calc.sv
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc: UART baud generator settings from a requested rate
// Path from input accept to result valid: input register, 34 + 36 + 36
// divider cells, mode select register, output register.
// Throughput: one word per cycle while the skid entry is empty; the three divider cell rows set the depth.
// Reset: clears all valid bits and loads the reset register values at once.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc
    import ubdc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_A_W-1:0]  cfg_addr,
    input  logic [CFG_D_W-1:0]  cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BAUD_W-1:0]   s_baud_rate,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [DINT_W-1:0]   m_divisor_integer,
    output logic [DFRAC_W-1:0]  m_divisor_fraction,
    output logic [MODE_W-1:0]   m_rate_mode,
    output logic [ACT_W-1:0]    m_actual_baud,
    output logic                m_calc_error
);

    localparam int SB1_W = BAUD_W + 1;
    localparam int SB2_W = FREF_W + 1;
    localparam int SB3_W = MODE_W + 1;

    logic [REF_W-1:0]    ref_clock_reg;
    logic [PREDIV_W-1:0] prediv_reg;
    logic [SEL_W-1:0]    mult_sel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_clock_reg <= REF_RESET;
            prediv_reg    <= PREDIV_RESET;
            mult_sel_reg  <= SEL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_REF_CLOCK: ref_clock_reg <= cfg_wdata[REF_W-1:0];
                REG_PREDIV:    prediv_reg    <= cfg_wdata[PREDIV_W-1:0];
                REG_MULT_SEL:  mult_sel_reg  <= cfg_wdata[SEL_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic accept;

    assign s_ready = en;
    assign accept  = s_valid && en;

    // input stage: error check and reference times multiplier
    logic              in_valid_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [BAUD_W-1:0] baud_reg;
    logic              err_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(ref_clock_reg) * PROD_W'(mult_factor(mult_sel_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= accept;
            prod_reg     <= prod_next;
            baud_reg     <= s_baud_rate;
            err_reg      <= (s_baud_rate == '0) || (prediv_reg == '0);
        end
    end

    // fref = product / predivider
    logic              d1_valid;
    logic [FREF_W-1:0] d1_fref;
    logic [SB1_W-1:0]  d1_sb;

    ubdc_divider #(
        .ND(PROD_W),
        .DW(PREDIV_W),
        .SW(SB1_W)
    ) u_div_fref (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (in_valid_reg),
        .dividend   (prod_reg),
        .divisor    (prediv_reg),
        .in_sb      ({err_reg, baud_reg}),
        .out_valid  (d1_valid),
        .quotient   (d1_fref),
        .remainder  (),
        .out_divisor(),
        .out_sb     (d1_sb)
    );

    // 4*fref / baud; the normal and double quotients are its upper bits
    logic              d2_valid;
    logic [CLK_W-1:0]  d2_q4;
    logic [BAUD_W-1:0] d2_r4;
    logic [SB2_W-1:0]  d2_sb;

    ubdc_divider #(
        .ND(CLK_W),
        .DW(BAUD_W),
        .SW(SB2_W)
    ) u_div_baud (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (d1_valid),
        .dividend   ({d1_fref, 2'b00}),
        .divisor    (d1_sb[BAUD_W-1:0]),
        .in_sb      ({d1_sb[BAUD_W], d1_fref}),
        .out_valid  (d2_valid),
        .quotient   (d2_q4),
        .remainder  (d2_r4),
        .out_divisor(),
        .out_sb     (d2_sb)
    );

    // mode select
    logic              sel_valid_reg;
    logic [CLK_W-1:0]  sel_clk_reg;
    logic [DIV_W-1:0]  sel_div_reg;
    rate_mode_t        sel_mode_reg;
    logic              sel_err_reg;

    logic [FREF_W-1:0] fref;
    logic [DIV_W-1:0]  q0;
    logic [DIV_W:0]    q1;
    logic [DIV_W-1:0]  div0;
    logic              exact0;
    logic              exact1;
    logic              retry1;
    logic              retry2;
    logic [CLK_W-1:0]  clk_next;
    logic [DIV_W-1:0]  div_next;
    rate_mode_t        mode_next;

    assign fref   = d2_sb[FREF_W-1:0];
    assign q0     = d2_q4[CLK_W-1:2];
    assign q1     = d2_q4[CLK_W-1:1];
    assign div0   = (q0 < DIV_W'(MIN_DIV)) ? DIV_W'(MIN_DIV) : q0;
    assign exact0 = (d2_r4 == '0) && (d2_q4[1:0] == 2'b00);
    assign exact1 = (d2_r4 == '0) && !d2_q4[0];
    assign retry1 = !exact0 && ((div0 >> LIMIT_SHIFT) == '0);
    assign retry2 = !exact1 && ((q1 >> LIMIT_SHIFT) == '0);

    always_comb begin
        if (!retry1) begin
            mode_next = MODE_NORMAL;
            div_next  = div0;
            clk_next  = {2'b00, fref};
        end else if (!retry2) begin
            mode_next = MODE_DOUBLE;
            div_next  = q1[DIV_W-1:0];
            clk_next  = {1'b0, fref, 1'b0};
        end else begin
            mode_next = MODE_QUAD;
            div_next  = d2_q4[DIV_W-1:0];
            clk_next  = {fref, 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_valid_reg <= 1'b0;
        end else if (en) begin
            sel_valid_reg <= d2_valid;
            sel_clk_reg   <= clk_next;
            sel_div_reg   <= div_next;
            sel_mode_reg  <= mode_next;
            sel_err_reg   <= d2_sb[FREF_W];
        end
    end

    // achieved baud = clk / div; a zero divisor yields an all-ones quotient
    logic             d3_valid;
    logic [CLK_W-1:0] d3_actual;
    logic [DIV_W-1:0] d3_div;
    logic [SB3_W-1:0] d3_sb;

    ubdc_divider #(
        .ND(CLK_W),
        .DW(DIV_W),
        .SW(SB3_W)
    ) u_div_actual (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (sel_valid_reg),
        .dividend   (sel_clk_reg),
        .divisor    (sel_div_reg),
        .in_sb      ({sel_err_reg, sel_mode_reg}),
        .out_valid  (d3_valid),
        .quotient   (d3_actual),
        .remainder  (),
        .out_divisor(d3_div),
        .out_sb     (d3_sb)
    );

    result_t res_next;

    always_comb begin
        res_next = '0;
        if (d3_sb[MODE_W]) begin
            res_next.calc_error = 1'b1;
        end else begin
            res_next.divisor_integer  = d3_div[DFRAC_W +: DINT_W];
            res_next.divisor_fraction = d3_div[DFRAC_W-1:0];
            res_next.rate_mode        = d3_sb[MODE_W-1:0];
            res_next.actual_baud      = (d3_actual[CLK_W-1:ACT_W] != '0) ? '1
                                        : d3_actual[ACT_W-1:0];
        end
    end

    // output register with skid entry; the pipeline holds while the skid is full
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    take;
    logic    arrive;

    assign en     = !skid_valid_reg;
    assign take   = out_valid_reg && m_ready;
    assign arrive = d3_valid && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (arrive) begin
            if (!out_valid_reg || take) begin
                out_reg       <= res_next;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res_next;
                skid_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_divisor_integer  = out_reg.divisor_integer;
    assign m_divisor_fraction = out_reg.divisor_fraction;
    assign m_rate_mode        = out_reg.rate_mode;
    assign m_actual_baud      = out_reg.actual_baud;
    assign m_calc_error       = out_reg.calc_error;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a pending output word");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid entry loaded while output was free");

    a_normal_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_valid_reg && !sel_err_reg && (sel_mode_reg == MODE_NORMAL)
        |-> (sel_div_reg >= DIV_W'(MIN_DIV)))
        else $error("normal mode divisor below floor");

    a_retry_small: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_valid_reg && !sel_err_reg && (sel_mode_reg != MODE_NORMAL)
        |-> ((sel_div_reg >> (LIMIT_SHIFT + 2)) == '0))
        else $error("retry divisor out of range");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.calc_error
        |-> (out_reg.actual_baud == '0) && (out_reg.divisor_integer == '0)
            && (out_reg.divisor_fraction == '0) && (out_reg.rate_mode == '0))
        else $error("error word carries nonzero fields");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the UART baud divisor calculator
// Requests baud rates under a series of PLL settings, predicts the divisor,
// clock mode and achieved rate of each accepted word, and checks every result
// word in order against that prediction, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb
    import ubdc_pkg::*;
;

    localparam int               CYCLE_LIMIT = 200000;
    localparam int               DRAIN_CYCLES = 150;
    localparam logic [CFG_A_W-1:0] REG_SPARE = 2'd3;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CFG_A_W-1:0]  cfg_addr;
    logic [CFG_D_W-1:0]  cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [BAUD_W-1:0]   s_baud_rate;
    logic                m_valid;
    logic                m_ready;
    logic [DINT_W-1:0]   m_divisor_integer;
    logic [DFRAC_W-1:0]  m_divisor_fraction;
    logic [MODE_W-1:0]   m_rate_mode;
    logic [ACT_W-1:0]    m_actual_baud;
    logic                m_calc_error;

    logic [REF_W-1:0]    ref_hz_cfg;
    logic [PREDIV_W-1:0] prediv_cfg;
    logic [SEL_W-1:0]    mult_sel_cfg;

    logic [BAUD_W-1:0] baud_request_q[$];
    result_t           divisor_settings_q[$];
    result_t           want;
    bit                in_taken = 1'b0;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;
    int                hold_left = 0;
    int                requests_queued = 0;
    int                requests_taken = 0;
    int                settings_checked = 0;
    int                mismatches = 0;
    int                error_hits = 0;
    int                mode_hits [3] = '{0, 0, 0};
    int                pll_settings_run = 0;
    int                cycle_count = 0;

    logic [BAUD_W-1:0] corner_bauds [25] = '{
        24'd0, 24'hFFFFFF, 24'd1, 24'd2, 24'd3, 24'd7, 24'd16, 24'd45, 24'd46,
        24'd300, 24'd9600, 24'd57600, 24'd115200, 24'd230400, 24'd921600,
        24'd1000000, 24'd1500000, 24'd2000000, 24'd3000000, 24'd10000000,
        24'd12000000, 24'd16000000, 24'h555555, 24'hAAAAAA, 24'd31250
    };

    uart_baud_divisor_calc u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_baud_rate        (s_baud_rate),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_divisor_integer  (m_divisor_integer),
        .m_divisor_fraction (m_divisor_fraction),
        .m_rate_mode        (m_rate_mode),
        .m_actual_baud      (m_actual_baud),
        .m_calc_error       (m_calc_error)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic longint unsigned pll_ref_hz();
        longint unsigned mul;
        if (prediv_cfg == 0) begin
            return 0;
        end
        if (mult_sel_cfg == 0) begin
            mul = MUL_ZERO;
        end else begin
            mul = MUL_UNIT;
            mul = mul * mult_sel_cfg;
        end
        return (ref_hz_cfg * mul) / prediv_cfg;
    endfunction

    function automatic result_t calc_divisor_settings(input logic [BAUD_W-1:0] baud);
        result_t           r;
        longint unsigned   b;
        longint unsigned   fref;
        longint unsigned   clk;
        longint unsigned   div;
        longint unsigned   act;
        logic [MODE_W-1:0] mode;
        r = '0;
        if (baud == 0 || prediv_cfg == 0) begin
            r.calc_error = 1'b1;
            return r;
        end
        b = baud;
        fref = pll_ref_hz();
        mode = MODE_NORMAL;
        clk = fref;
        div = clk / b;
        if (div < MIN_DIV) begin
            div = MIN_DIV;
        end
        if (clk % b != 0 && div / 16 < DIV_LIMIT) begin
            mode = MODE_DOUBLE;
            clk = fref * 2;
            div = clk / b;
            if (clk % b != 0 && div / 16 < DIV_LIMIT) begin
                mode = MODE_QUAD;
                clk = fref * 4;
                div = clk / b;
            end
        end
        if (div == 0) begin
            act = 64'hFFFF_FFFF;
        end else begin
            act = clk / div;
            if (act > 64'hFFFF_FFFF) begin
                act = 64'hFFFF_FFFF;
            end
        end
        r.divisor_integer  = DINT_W'(div / 16);
        r.divisor_fraction = DFRAC_W'(div % 16);
        r.rate_mode        = mode;
        r.actual_baud      = ACT_W'(act);
        return r;
    endfunction

    // mix of exact divisors, tiny rates, rates near the floor and above the clock
    function automatic logic [BAUD_W-1:0] pick_baud();
        longint unsigned fref;
        longint unsigned v;
        longint unsigned k;
        int unsigned     roll;
        fref = pll_ref_hz();
        roll = $urandom_range(99);
        v = {$urandom} & 32'hFF_FFFF;
        if (roll < 5) begin
            v = 0;
        end else if (roll < 20) begin
            v = $urandom_range(64, 1);
        end else if (roll < 35 && fref > 0) begin
            k = $urandom_range(4096, 1);
            if (fref % k == 0) begin
                v = fref / k;
            end
        end else if (roll < 50 && fref > 0) begin
            v = fref / $urandom_range(24, 1) + $urandom_range(3);
        end else if (roll < 60 && fref < 64'hFF_FFFF) begin
            v = $urandom_range(32'hFF_FFFF, 32'(fref) + 1);
        end else if (roll < 80) begin
            v = {$urandom} >> $urandom_range(31, 8);
        end
        if (v > 64'hFF_FFFF) begin
            v = {$urandom} & 32'hFF_FFFF;
        end
        return BAUD_W'(v);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            mismatches++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [CFG_D_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            REG_REF_CLOCK: ref_hz_cfg = data;
            REG_PREDIV:    prediv_cfg = data[PREDIV_W-1:0];
            REG_MULT_SEL:  mult_sel_cfg = data[SEL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_pll(input logic [CFG_D_W-1:0] ref_hz, input logic [CFG_D_W-1:0] prediv,
                           input logic [CFG_D_W-1:0] sel);
        write_reg(REG_REF_CLOCK, ref_hz);
        write_reg(REG_PREDIV, prediv);
        write_reg(REG_MULT_SEL, sel);
        pll_settings_run++;
    endtask

    task automatic queue_request(input logic [BAUD_W-1:0] baud);
        baud_request_q = {baud_request_q, baud};
        requests_queued++;
    endtask

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (requests_taken != requests_queued || divisor_settings_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic run_requests(input int n, input int unsigned send_pct,
                                input int unsigned recv_pct, input int hold);
        @(posedge aclk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        hold_left      = hold;
        repeat (n) queue_request(pick_baud());
        wait_idle();
    endtask

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (baud_request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid     <= 1'b1;
                s_baud_rate <= baud_request_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver; a long hold-off backs the pipeline up into the input
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) begin
            divisor_settings_q = {divisor_settings_q, calc_divisor_settings(s_baud_rate)};
            requests_taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (divisor_settings_q.size() == 0) begin
                $error("result word with no request pending");
                mismatches++;
            end else begin
                want = divisor_settings_q.pop_front();
                check_field("divisor_integer", 32'(want.divisor_integer),
                            32'(m_divisor_integer));
                check_field("divisor_fraction", 32'(want.divisor_fraction),
                            32'(m_divisor_fraction));
                check_field("rate_mode", 32'(want.rate_mode), 32'(m_rate_mode));
                check_field("actual_baud", want.actual_baud, m_actual_baud);
                check_field("calc_error", 32'(want.calc_error), 32'(m_calc_error));
                settings_checked++;
                if (want.calc_error) begin
                    error_hits++;
                end else begin
                    mode_hits[want.rate_mode]++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_baud_rate  = '0;
        m_ready      = 1'b0;
        ref_hz_cfg   = REF_RESET;
        prediv_cfg   = PREDIV_RESET;
        mult_sel_cfg = SEL_RESET;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // corner rates under the reset PLL setting
        @(posedge aclk);
        pll_settings_run++;
        foreach (corner_bauds[i]) queue_request(corner_bauds[i]);
        wait_idle();
        run_requests(150, 52, 0, 0);

        set_pll(CFG_D_W'(26'h3FF_FFFF), CFG_D_W'(1), CFG_D_W'(3));
        run_requests(150, 0, 52, 0);

        // slow reference: retries for high rates end in a zero divisor
        set_pll(CFG_D_W'(1000), CFG_D_W'(1), CFG_D_W'(0));
        run_requests(120, 17, 17, 0);

        set_pll(CFG_D_W'(0), CFG_D_W'(5), CFG_D_W'(1));
        run_requests(30, 0, 0, 0);

        // reference truncates to zero
        set_pll(CFG_D_W'(1), CFG_D_W'(63), CFG_D_W'(0));
        run_requests(30, 52, 0, 0);

        set_pll(CFG_D_W'($urandom_range(50000000, 1)), CFG_D_W'(0), CFG_D_W'(2));
        run_requests(40, 0, 52, 0);

        set_pll(CFG_D_W'($urandom_range(50000000, 1)), CFG_D_W'(63), CFG_D_W'(2));
        run_requests(150, 17, 17, 0);

        // junk upper bits and a write past the register list
        set_pll(CFG_D_W'(50000000), {20'hFFFFF, 6'd7}, {24'hABCDEF, 2'd1});
        write_reg(REG_SPARE, '1);
        run_requests(150, 0, 0, 400);

        set_pll(CFG_D_W'($urandom_range(50000000, 1)), CFG_D_W'($urandom),
                CFG_D_W'($urandom));
        run_requests(120, 17, 17, 0);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Checked %0d result words from %0d requests over %0d PLL settings.",
                 settings_checked, requests_taken, pll_settings_run);
        $display("Modes normal/double/quad: %0d/%0d/%0d, error words: %0d, mismatches: %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], error_hits, mismatches);
        if (mismatches == 0 && divisor_settings_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
